@@ src/bidq_pkg.sv @@
// Shared types and defaults for the bounded integer deque with search.
`timescale 1ns / 1ps

package bidq_pkg;

  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ src/bidq_ram.sv @@
// Entry store: one write port and one registered read port.
`timescale 1ns / 1ps

module bidq_ram
  import bidq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bounded_int_list_deque_search.sv @@
// Top level of the bounded integer deque with search: sequencer and result register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_stall_o | op_i, value_i
//   out     | output    | out_valid_o/ out_stall_i| value_out_o, found_o, status_o, entries_o
//
// An accepted operation passes the execute state and the result state, where its result is
// loaded into the result register; a pop from a non-empty list also passes a read state. A
// remove or a query walks the store one entry a cycle through the single read port. The
// input is free again in the cycle after the result is loaded, and stays stalled while a
// finished result waits behind a full, stalled result register. Reset clears the front
// position, the entry count and all handshake state; the store itself is not cleared.
`timescale 1ns / 1ps

module bounded_int_list_deque_search
  import bidq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_out_o,
  output logic               found_o,
  output logic [1:0]         status_o,
  output logic [CW-1:0]      entries_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_POPRD  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic signed [31:0] val_q, val_d;
  logic [AW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      k_q, k_d;
  logic signed [31:0] res_value_q, res_value_d;
  logic               res_found_q, res_found_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] value_out_q;
  logic               found_q;
  status_e            status_q;
  logic [CW-1:0]      entries_q;

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [CW-1:0]      rd_off;
  logic signed [31:0] rdata;
  logic               out_free;
  logic               full;
  logic               empty;
  logic [AW-1:0]      front_dec;
  logic [AW-1:0]      front_inc;
  logic [CW-1:0]      k_p1;
  logic [CW-1:0]      k_p2;
  logic               load_out;

  // Store index of the entry at a given offset from the front.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
  assign k_p1      = k_q + CW'(1);
  assign k_p2      = k_q + CW'(2);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    front_d      = front_q;
    count_d      = count_q;
    k_d          = k_q;
    res_value_d  = res_value_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = slot(front_q, count_q);
    wdata        = val_q;
    re           = 1'b0;
    rd_off       = '0;
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          val_d   = value_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_value_d  = '0;
        res_found_d  = 1'b0;
        res_status_d = ST_OK;
        state_d      = S_RESULT;
        unique case (op_q)
          OP_PUSH_FRONT: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = front_dec;
              front_d = front_dec;
              count_d = count_q + CW'(1);
            end
          end
          OP_PUSH_BACK: begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          OP_POP_FRONT: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else begin
              re      = 1'b1;
              front_d = front_inc;
              count_d = count_q - CW'(1);
              state_d = S_POPRD;
            end
          end
          OP_POP_BACK: begin
            if (empty) begin
              res_status_d = ST_EMPTY;
            end else begin
              re      = 1'b1;
              rd_off  = count_q - CW'(1);
              count_d = count_q - CW'(1);
              state_d = S_POPRD;
            end
          end
          OP_REMOVE, OP_QUERY: begin
            if (!empty) begin
              re      = 1'b1;
              k_d     = '0;
              state_d = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POPRD: begin
        res_value_d = rdata;
        state_d     = S_RESULT;
      end
      S_SCAN: begin
        if (rdata == val_q) begin
          res_found_d = 1'b1;
          if (op_q == OP_QUERY) begin
            state_d = S_RESULT;
          end else if (k_p1 < count_q) begin
            // Close the gap: read the next entry, write it one place nearer the front.
            re      = 1'b1;
            rd_off  = k_p1;
            state_d = S_SHIFT;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_RESULT;
          end
        end else if (k_p1 < count_q) begin
          re      = 1'b1;
          rd_off  = k_p1;
          k_d     = k_p1;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = slot(front_q, k_q);
        wdata = rdata;
        if (k_p2 < count_q) begin
          re     = 1'b1;
          rd_off = k_p2;
          k_d    = k_p1;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    k_q          <= k_d;
    res_value_q  <= res_value_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    if (load_out) begin
      value_out_q <= res_value_q;
      found_q     <= res_found_q;
      status_q    <= res_status_q;
      entries_q   <= count_q;
    end
  end

  bidq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (slot(front_q, rd_off)),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign value_out_o = value_out_q;
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign entries_o   = entries_q;

endmodule
